>>> rtl/core/tssb_pkg.sv
// ----------------------------------------------------------------------------
// tssb_pkg
// Shared types and constants for the time sorted spike buffer.
// ----------------------------------------------------------------------------
package tssb_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int TIME_W       = 48;
  localparam int NEURON_W     = 64;
  localparam int INDEX_W      = 6;
  localparam int COUNT_W      = 7;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    STATUS_INSERTED  = 3'd0,
    STATUS_DUPLICATE = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_READ_OK   = 3'd3,
    STATUS_BAD_INDEX = 3'd4
  } status_e;

  typedef struct packed {
    op_e                 operation;
    logic [TIME_W-1:0]   spike_time;
    logic [NEURON_W-1:0] neuron_id;
    logic [INDEX_W-1:0]  read_index;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [TIME_W-1:0]   entry_time;
    logic [NEURON_W-1:0] entry_neuron;
    logic [COUNT_W-1:0]  entry_count;
  } out_item_t;

  // Control shared by every cell of the row.
  typedef struct packed {
    logic cmp_en;
    logic upd_en;
  } cell_ctrl_t;

endpackage

>>> rtl/core/tssb_cell.sv
// ----------------------------------------------------------------------------
// tssb_cell
// One slot of the sorted row: holds an entry, compares it to the incoming
// spike, and either keeps it, takes the new spike, or takes its left neighbor.
// ----------------------------------------------------------------------------
module tssb_cell (
  input  logic                          clk_i,
  input  tssb_pkg::cell_ctrl_t          ctrl_i,
  input  logic                          occupied_i,
  input  logic [tssb_pkg::TIME_W-1:0]   new_time_i,
  input  logic [tssb_pkg::NEURON_W-1:0] new_neuron_i,
  input  logic [tssb_pkg::TIME_W-1:0]   left_time_i,
  input  logic [tssb_pkg::NEURON_W-1:0] left_neuron_i,
  input  logic                          left_le_i,
  output logic [tssb_pkg::TIME_W-1:0]   time_o,
  output logic [tssb_pkg::NEURON_W-1:0] neuron_o,
  output logic                          le_o,
  output logic                          dup_o
);
  import tssb_pkg::*;

  logic [TIME_W-1:0]   time_q, time_d;
  logic [NEURON_W-1:0] neuron_q, neuron_d;
  logic                le_q, le_d;
  logic                dup_q, dup_d;

  always_comb begin
    le_d  = le_q;
    dup_d = dup_q;
    if (ctrl_i.cmp_en) begin
      le_d  = (time_q <= new_time_i);
      dup_d = (time_q == new_time_i) && (neuron_q == new_neuron_i);
    end
  end

  assign le_o  = occupied_i & le_q;
  assign dup_o = occupied_i & dup_q;

  // Entries at or before the new time stay put; the first slot after them
  // takes the new spike and every later slot moves one place to the right.
  always_comb begin
    time_d   = time_q;
    neuron_d = neuron_q;
    if (ctrl_i.upd_en && !le_o) begin
      if (left_le_i) begin
        time_d   = new_time_i;
        neuron_d = new_neuron_i;
      end else begin
        time_d   = left_time_i;
        neuron_d = left_neuron_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    time_q   <= time_d;
    neuron_q <= neuron_d;
    le_q     <= le_d;
    dup_q    <= dup_d;
  end

  assign time_o   = time_q;
  assign neuron_o = neuron_q;

endmodule

>>> rtl/core/tssb_cell_row.sv
// ----------------------------------------------------------------------------
// tssb_cell_row
// The row of cells, with the duplicate reduction and the read selection.
// ----------------------------------------------------------------------------
module tssb_cell_row (
  input  logic                          clk_i,
  input  tssb_pkg::cell_ctrl_t          ctrl_i,
  input  logic [tssb_pkg::CNT_W-1:0]    fill_i,
  input  logic [tssb_pkg::TIME_W-1:0]   new_time_i,
  input  logic [tssb_pkg::NEURON_W-1:0] new_neuron_i,
  input  logic [tssb_pkg::INDEX_W-1:0]  rd_index_i,
  output logic                          dup_o,
  output logic [tssb_pkg::TIME_W-1:0]   rd_time_o,
  output logic [tssb_pkg::NEURON_W-1:0] rd_neuron_o
);
  import tssb_pkg::*;

  logic [TIME_W-1:0]       cell_time   [BUFFER_DEPTH];
  logic [NEURON_W-1:0]     cell_neuron [BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] cell_le;
  logic [BUFFER_DEPTH-1:0] cell_dup;

  for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
    logic                occupied;
    logic [TIME_W-1:0]   left_time;
    logic [NEURON_W-1:0] left_neuron;
    logic                left_le;

    assign occupied = (CNT_W'(i) < fill_i);

    if (i == 0) begin : g_head
      // The head slot has nothing to its left, so it behaves as if its
      // left neighbor were at or before the new time.
      assign left_time   = new_time_i;
      assign left_neuron = new_neuron_i;
      assign left_le     = 1'b1;
    end else begin : g_body
      assign left_time   = cell_time[i-1];
      assign left_neuron = cell_neuron[i-1];
      assign left_le     = cell_le[i-1];
    end

    tssb_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl_i),
      .occupied_i    (occupied),
      .new_time_i    (new_time_i),
      .new_neuron_i  (new_neuron_i),
      .left_time_i   (left_time),
      .left_neuron_i (left_neuron),
      .left_le_i     (left_le),
      .time_o        (cell_time[i]),
      .neuron_o      (cell_neuron[i]),
      .le_o          (cell_le[i]),
      .dup_o         (cell_dup[i])
    );
  end

  assign dup_o = |cell_dup;

  always_comb begin
    rd_time_o   = '0;
    rd_neuron_o = '0;
    for (int i = 0; i < BUFFER_DEPTH; i++) begin
      if (32'(rd_index_i) == i) begin
        rd_time_o   = cell_time[i];
        rd_neuron_o = cell_neuron[i];
      end
    end
  end

endmodule

>>> rtl/core/time_sorted_spike_buffer_core.sv
// ----------------------------------------------------------------------------
// time_sorted_spike_buffer_core
// Spike buffer kept sorted by time in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one transaction per item: an add of a spike
//   (time, neuron) or a read of the entry at read_index. Every item gives
//   exactly one result transaction on the output channel, with a status and
//   the number of stored entries after the item.
//   An item passes through an accept step, a compare step in which every
//   cell compares its entry to the new spike, and an update step in which the
//   row reduces the duplicate flags, shifts right behind the insertion point
//   and registers the result. The block takes no new item until the current
//   one has left its update step, as the compare and update passes run
//   through the cell row.
//   Reset empties the buffer at once (the fill count goes to zero); no
//   clearing pass is needed. The input is accepted again while a result
//   waits in the output register; when the receiver stalls with a result
//   still held, the next item waits in its update step and the input stalls.
// ----------------------------------------------------------------------------
module time_sorted_spike_buffer_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tssb_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tssb_pkg::out_item_t  out_item_o
);
  import tssb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                state_q, state_d;
  in_item_t              item_q;
  logic [CNT_W-1:0]      fill_q, fill_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  cell_ctrl_t            ctrl;
  logic                  dup_any;
  logic [TIME_W-1:0]     rd_time;
  logic [NEURON_W-1:0]   rd_neuron;
  logic                  out_free;
  logic                  is_add;
  logic                  full;
  logic                  index_ok;
  logic                  finish;

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_add   = (item_q.operation == OP_ADD);
  assign full     = (fill_q == CNT_W'(BUFFER_DEPTH));
  assign index_ok = (32'(item_q.read_index) < 32'(fill_q));
  assign finish   = (state_q == ST_DONE) && out_free;

  assign ctrl.cmp_en = (state_q == ST_CMP);
  assign ctrl.upd_en = finish && is_add && !dup_any && !full;

  tssb_cell_row u_row (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .fill_i       (fill_q),
    .new_time_i   (item_q.spike_time),
    .new_neuron_i (item_q.neuron_id),
    .rd_index_i   (item_q.read_index),
    .dup_o        (dup_any),
    .rd_time_o    (rd_time),
    .rd_neuron_o  (rd_neuron)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CMP;
      end
      ST_CMP: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign fill_d = ctrl.upd_en ? fill_q + CNT_W'(1) : fill_q;

  always_comb begin
    out_d              = out_q;
    out_d.entry_time   = '0;
    out_d.entry_neuron = '0;
    out_d.entry_count  = COUNT_W'(fill_d);
    if (is_add) begin
      if (dup_any) begin
        out_d.status = STATUS_DUPLICATE;
      end else if (full) begin
        out_d.status = STATUS_FULL;
      end else begin
        out_d.status = STATUS_INSERTED;
      end
    end else if (index_ok) begin
      out_d.status       = STATUS_READ_OK;
      out_d.entry_time   = rd_time;
      out_d.entry_neuron = rd_neuron;
    end else begin
      out_d.status = STATUS_BAD_INDEX;
    end
  end

  assign out_valid_d = finish ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      item_q <= in_item_i;
    end
    if (finish) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(BUFFER_DEPTH))
    else $error("fill count exceeds buffer depth");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != $past(fill_q) |-> $past(ctrl.upd_en) && fill_q == $past(fill_q) + CNT_W'(1))
    else $error("fill count changed without an insertion");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result appeared without a finished item");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == STATUS_INSERTED |-> out_q.entry_count != '0)
    else $error("insertion reported with an empty buffer");

  a_no_update_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.upd_en |-> !out_valid_q || !out_stall_i)
    else $error("row updated while the result register was held");
`endif

endmodule

>>> tb/tssb_result_checker.sv
// ----------------------------------------------------------------------------
// tssb_result_checker
// Predicts and checks every result of the time sorted spike buffer.
// ----------------------------------------------------------------------------
// Both channels are sampled on the falling clock edge. All inputs change only
// on the rising edge, so the values seen there decide what the next rising
// edge accepts. Each accepted item is run through a private copy of the
// sorted buffer. The predicted result is queued, and each accepted result is
// compared field by field with the oldest entry of that queue.
// ----------------------------------------------------------------------------
module tssb_result_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  tssb_pkg::in_item_t   in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  tssb_pkg::out_item_t  out_item_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o,
  output logic [4:0]           status_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tssb_pkg::*;

  logic [TIME_W-1:0]   sorted_times   [BUFFER_DEPTH];
  logic [NEURON_W-1:0] sorted_neurons [BUFFER_DEPTH];
  int                  held_count;
  out_item_t           expected_results [$];
  out_item_t           predicted;

  task automatic predict_result(input in_item_t item, output out_item_t res);
    int pos;
    bit dup;
    res = '0;
    pos = 0;
    dup = 1'b0;
    if (item.operation == OP_ADD) begin
      // The new spike goes behind every stored entry of equal or lower time.
      for (int i = 0; i < held_count; i++) begin
        if (sorted_times[i] == item.spike_time && sorted_neurons[i] == item.neuron_id)
          dup = 1'b1;
        if (sorted_times[i] <= item.spike_time)
          pos = i + 1;
      end
      if (dup) begin
        res.status = STATUS_DUPLICATE;
      end else if (held_count >= BUFFER_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        for (int i = held_count; i > pos; i--) begin
          sorted_times[i]   = sorted_times[i-1];
          sorted_neurons[i] = sorted_neurons[i-1];
        end
        sorted_times[pos]   = item.spike_time;
        sorted_neurons[pos] = item.neuron_id;
        held_count++;
        res.status = STATUS_INSERTED;
      end
    end else if (int'(item.read_index) < held_count) begin
      res.status       = STATUS_READ_OK;
      res.entry_time   = sorted_times[item.read_index];
      res.entry_neuron = sorted_neurons[item.read_index];
    end else begin
      res.status = STATUS_BAD_INDEX;
    end
    res.entry_count = COUNT_W'(held_count);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result transaction: status %0d count %0d",
             got.status, got.entry_count);
      fail_count_o++;
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d actual %0d", want.status, got.status);
        fail_count_o++;
      end
      if (got.entry_time !== want.entry_time) begin
        $error("entry_time: expected %h actual %h", want.entry_time, got.entry_time);
        fail_count_o++;
      end
      if (got.entry_neuron !== want.entry_neuron) begin
        $error("entry_neuron: expected %h actual %h", want.entry_neuron, got.entry_neuron);
        fail_count_o++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d actual %0d", want.entry_count, got.entry_count);
        fail_count_o++;
      end
      status_seen_o[want.status] = 1'b1;
      checked_o++;
    end
  endtask

  initial begin
    fail_count_o  = 0;
    pending_o     = 0;
    checked_o     = 0;
    status_seen_o = '0;
    held_count    = 0;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      held_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i)
        check_result(out_item_i);
      if (in_valid_i && !in_stall_i) begin
        predict_result(in_item_i, predicted);
        expected_results.insert(expected_results.size(), predicted);
      end
    end
    pending_o = expected_results.size();
  end

endmodule

>>> tb/time_sorted_spike_buffer_core_tb.sv
// ----------------------------------------------------------------------------
// time_sorted_spike_buffer_core_tb
// Stimulus and verdict for the time sorted spike buffer core.
// ----------------------------------------------------------------------------
// A short directed run covers the empty buffer, the extreme times and ids,
// equal times, duplicates and ignored fields. Random traffic then fills the
// buffer and keeps working on it while full, under four mixes of sender
// idling and receiver stalling. A separate checker predicts and compares
// every result transaction.
// ----------------------------------------------------------------------------
module time_sorted_spike_buffer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tssb_pkg::*;

  localparam int RANDOM_PER_PHASE = 475;
  localparam int SETTLE_CYCLES    = 8;
  localparam int TIMEOUT_NS       = 5_000_000;

  localparam logic [TIME_W-1:0]   MAX_TIME   = '1;
  localparam logic [NEURON_W-1:0] MAX_NEURON = '1;
  localparam logic [INDEX_W-1:0]  MAX_INDEX  = '1;

  typedef struct packed {
    logic [TIME_W-1:0]   stamp;
    logic [NEURON_W-1:0] neuron;
  } spike_key_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  int         fail_count;
  int         pending;
  int         checked;
  logic [4:0] status_seen;

  int idle_pct  = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int phase_idle  [4] = '{0, 78, 0, 12};
  int phase_stall [4] = '{0, 0, 78, 12};

  logic [TIME_W-1:0]   time_pool   [8];
  logic [NEURON_W-1:0] neuron_pool [6];
  spike_key_t          sent_spikes [$];

  always #5 clk = ~clk;

  time_sorted_spike_buffer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  tssb_result_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_item_i    (out_item),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .status_seen_o (status_seen)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    #(TIMEOUT_NS);
    $display("time_sorted_spike_buffer_core_tb failed");
    $finish;
  end

  function automatic in_item_t make_item(op_e op, logic [TIME_W-1:0] t,
                                         logic [NEURON_W-1:0] n,
                                         logic [INDEX_W-1:0] idx);
    in_item_t item;
    item.operation  = op;
    item.spike_time = t;
    item.neuron_id  = n;
    item.read_index = idx;
    return item;
  endfunction

  // Adds draw times and ids from small pools half of the time, so that equal times and
  // duplicates are common; some adds repeat an earlier spike outright.
  function automatic in_item_t random_item(int add_pct);
    in_item_t   item;
    logic [63:0] r;
    spike_key_t key;
    r = {$urandom(), $urandom()};
    item.spike_time = r[TIME_W-1:0];
    item.neuron_id  = {$urandom(), $urandom()};
    item.read_index = $urandom_range(0, 1) ? INDEX_W'($urandom_range(0, 15))
                                           : INDEX_W'($urandom());
    item.operation  = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_READ;
    if (item.operation == OP_ADD) begin
      if ($urandom_range(0, 99) < 15 && sent_spikes.size() > 0) begin
        key = sent_spikes[$urandom_range(0, sent_spikes.size() - 1)];
        item.spike_time = key.stamp;
        item.neuron_id  = key.neuron;
      end else begin
        if ($urandom_range(0, 1))
          item.spike_time = time_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 1))
          item.neuron_id = neuron_pool[$urandom_range(0, 5)];
      end
    end
    return item;
  endfunction

  // Presents one item and returns right after the edge that accepts it.
  // Valid stays high when the next item follows without a gap.
  task automatic send_item(input in_item_t item);
    bit accepted;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do begin
      @(negedge clk);
      accepted = !in_stall;
      @(posedge clk);
    end while (!accepted);
    if (item.operation == OP_ADD)
      sent_spikes.insert(sent_spikes.size(), {item.spike_time, item.neuron_id});
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [63:0] r;
    time_pool[0]   = '0;
    time_pool[1]   = MAX_TIME;
    neuron_pool[0] = '0;
    neuron_pool[1] = MAX_NEURON;
    for (int i = 2; i < 8; i++) begin
      r = {$urandom(), $urandom()};
      time_pool[i] = r[TIME_W-1:0];
    end
    for (int i = 2; i < 6; i++)
      neuron_pool[i] = {$urandom(), $urandom()};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 20;
    stall_pct <= 20;
    // Reads of an empty buffer are out of range.
    send_item(make_item(OP_READ, '0, '0, '0));
    send_item(make_item(OP_READ, '0, '0, MAX_INDEX));
    send_item(make_item(OP_ADD, '0, '0, '0));
    send_item(make_item(OP_ADD, MAX_TIME, MAX_NEURON, '0));
    send_item(make_item(OP_ADD, MAX_TIME, MAX_NEURON, '0));
    // Equal time with another neuron lands behind the earlier entry.
    send_item(make_item(OP_ADD, '0, MAX_NEURON, '0));
    send_item(make_item(OP_ADD, '0, '0, '0));
    send_item(make_item(OP_ADD, 48'h0000_0001_8000, 64'd5, '0));
    send_item(make_item(OP_ADD, 48'h0000_0000_0001, '0, MAX_INDEX));
    send_item(make_item(OP_ADD, MAX_TIME, '0, '0));
    for (int i = 0; i < 7; i++)
      send_item(make_item(OP_READ, '0, '0, INDEX_W'(i)));
    send_item(make_item(OP_READ, MAX_TIME, MAX_NEURON, INDEX_W'(7)));
    send_item(make_item(OP_READ, MAX_TIME, MAX_NEURON, MAX_INDEX));
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = phase_idle[phase];
      stall_pct <= phase_stall[phase];
      repeat (RANDOM_PER_PHASE)
        send_item(random_item(phase < 2 ? 10 : 25));
      drain_results();
      if (phase == 1) begin
        // By now the buffer is full: a duplicate still reports as duplicate.
        send_item(make_item(OP_ADD, '0, '0, '0));
        send_item(make_item(OP_ADD, 48'h0000_1234_0000, {$urandom(), $urandom()}, '0));
        send_item(make_item(OP_READ, '0, '0, '0));
        send_item(make_item(OP_READ, '0, '0, MAX_INDEX));
        drain_results();
      end
    end

    $display("Run covered %0d items, directed and random over four idle/stall mixes;",
             items_sent);
    $display("%0d results compared, statuses seen (one bit per code): %b",
             checked, status_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("time_sorted_spike_buffer_core_tb passed");
    end else begin
      $display("time_sorted_spike_buffer_core_tb failed");
    end
    $finish;
  end

endmodule
